// ----- rtl/dege_pkg.sv -----
// dege_pkg: shared widths, codes and word types of the gene recombination block
`default_nettype none

package dege_pkg;

    localparam int GENE_BITS = 32;
    localparam int DRAW_W    = 16;
    localparam int WEIGHT_W  = 16;
    localparam int RATE_W    = 17;
    localparam int F_FRAC    = 14;
    localparam int CFG_W     = (GENE_BITS > RATE_W) ? GENE_BITS : RATE_W;
    localparam int CFG_IDX_W = 3;

    localparam int MAG_W  = GENE_BITS + 1;
    localparam int PROD_W = MAG_W + WEIGHT_W;
    localparam int Q_W    = PROD_W - F_FRAC;
    localparam int S_W    = Q_W + 1;

    typedef logic signed [GENE_BITS-1:0] t_gene;
    typedef logic [DRAW_W-1:0]           t_draw;

    typedef enum logic [1:0] {
        MODE_DE,
        MODE_ADE,
        MODE_REVDE,
        MODE_DEX3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RATE    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = CFG_IDX_W'(4);

    localparam logic [WEIGHT_W-1:0] WEIGHT_RST  = WEIGHT_W'(8192);
    localparam logic [RATE_W-1:0]   RATE_RST    = RATE_W'(58982);
    localparam t_gene               FLOOR_RST   = t_gene'(-65536);
    localparam t_gene               CEILING_RST = t_gene'(65536);

    typedef struct packed {
        t_gene parent_a;
        t_gene parent_b;
        t_gene parent_c;
        t_gene parent_d;
        t_gene parent_e;
        t_gene parent_f;
        t_gene parent_g;
        t_draw draw_one;
        t_draw draw_two;
        t_draw draw_three;
    } t_in_word;

    typedef struct packed {
        t_gene child_one;
        t_gene child_two;
        t_gene child_three;
    } t_out_word;

    // word plus the mutants already made, carried alongside a mutation unit
    typedef struct packed {
        t_in_word word;
        t_gene    m1;
        t_gene    m2;
    } t_side;

endpackage

`default_nettype wire

// ----- rtl/diff_evo_gene_recombine.sv -----
// diff_evo_gene_recombine: one gene position of rand/1/bin differential evolution
// usage:
//   input channel i_in_valid / o_in_ready carries one word of seven parent genes
//   (Q16.16) and three 16-bit uniform draws; output channel o_out_valid /
//   i_out_ready carries one word of three child genes.
//   configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data):
//   index 0 mode, 1 weight F (Q2.14), 2 crossover rate CR (Q0.16, 65536 = all),
//   3 gene floor, 4 gene ceiling; write only while no word is in flight.
//   throughput: one word per cycle while the receiver keeps i_out_ready high.
//   path: three mutation units of five stages each run in series (the revde
//   chain needs the first and second mutant before the third), then one
//   crossover output register.
//   stalls: ready runs back stage by stage, so empty stages keep filling while
//   the receiver holds off; nothing is dropped or repeated.
//   reset: all stage valid bits clear, registers return to de mode, F = 0.5,
//   CR = 58982, floor -1.0, ceiling 1.0.
`default_nettype none

module diff_evo_gene_recombine (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire dege_pkg::t_in_word                    i_in_word,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output dege_pkg::t_out_word                        o_out_word,
    input  wire logic                                  i_cfg_we,
    input  wire logic [dege_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [dege_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int G = dege_pkg::GENE_BITS;

    dege_pkg::t_mode                      r_mode;
    logic [dege_pkg::WEIGHT_W-1:0]        r_weight;
    logic [dege_pkg::RATE_W-1:0]          r_rate;
    dege_pkg::t_gene                      r_floor;
    dege_pkg::t_gene                      r_ceiling;

    dege_pkg::t_side                      w_side1;
    logic                                 u1_valid, u1_ready;
    dege_pkg::t_gene                      u1_mut;
    dege_pkg::t_side                      u1_side;

    dege_pkg::t_side                      w_side2;
    dege_pkg::t_gene                      w_base2, w_x2, w_y2;
    logic                                 u2_valid, u2_ready;
    dege_pkg::t_gene                      u2_mut;
    dege_pkg::t_side                      u2_side;

    dege_pkg::t_side                      w_side3;
    dege_pkg::t_gene                      w_base3, w_x3, w_y3;
    logic                                 u3_valid;
    dege_pkg::t_gene                      u3_mut;
    dege_pkg::t_side                      u3_side;

    logic                                 w_en_out;
    logic                                 w_load;
    logic                                 r_ov;
    dege_pkg::t_out_word                  r_out;
    dege_pkg::t_out_word                  n_out;

    function automatic dege_pkg::t_gene pick_gene(
        input dege_pkg::t_gene              mutant,
        input dege_pkg::t_gene              fallback,
        input dege_pkg::t_draw              draw,
        input logic [dege_pkg::RATE_W-1:0]  rate
    );
        logic keep;
        keep = rate[dege_pkg::RATE_W-1] || ({1'b0, draw} < rate);
        return keep ? mutant : fallback;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= dege_pkg::MODE_DE;
            r_weight  <= dege_pkg::WEIGHT_RST;
            r_rate    <= dege_pkg::RATE_RST;
            r_floor   <= dege_pkg::FLOOR_RST;
            r_ceiling <= dege_pkg::CEILING_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dege_pkg::CFG_MODE:    r_mode    <= dege_pkg::t_mode'(i_cfg_data[1:0]);
                dege_pkg::CFG_WEIGHT:  r_weight  <= i_cfg_data[dege_pkg::WEIGHT_W-1:0];
                dege_pkg::CFG_RATE:    r_rate    <= i_cfg_data[dege_pkg::RATE_W-1:0];
                dege_pkg::CFG_FLOOR:   r_floor   <= i_cfg_data[G-1:0];
                dege_pkg::CFG_CEILING: r_ceiling <= i_cfg_data[G-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_side1      = '0;
        w_side1.word = i_in_word;
    end

    dege_mutate u_mut1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_base    (i_in_word.parent_a),
        .i_x       (i_in_word.parent_b),
        .i_y       (i_in_word.parent_c),
        .i_side    (w_side1),
        .o_valid   (u1_valid),
        .i_ready   (u1_ready),
        .o_mutant  (u1_mut),
        .o_side    (u1_side),
        .i_weight  (r_weight),
        .i_floor   (r_floor),
        .i_ceiling (r_ceiling)
    );

    always_comb begin
        w_side2    = u1_side;
        w_side2.m1 = u1_mut;
        case (r_mode)
            dege_pkg::MODE_REVDE: begin
                w_base2 = u1_side.word.parent_b;
                w_x2    = u1_side.word.parent_c;
                w_y2    = u1_mut;
            end
            dege_pkg::MODE_DEX3: begin
                w_base2 = u1_side.word.parent_a;
                w_x2    = u1_side.word.parent_d;
                w_y2    = u1_side.word.parent_e;
            end
            default: begin
                w_base2 = u1_side.word.parent_b;
                w_x2    = u1_side.word.parent_c;
                w_y2    = u1_side.word.parent_a;
            end
        endcase
    end

    dege_mutate u_mut2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (u1_valid),
        .o_ready   (u1_ready),
        .i_base    (w_base2),
        .i_x       (w_x2),
        .i_y       (w_y2),
        .i_side    (w_side2),
        .o_valid   (u2_valid),
        .i_ready   (u2_ready),
        .o_mutant  (u2_mut),
        .o_side    (u2_side),
        .i_weight  (r_weight),
        .i_floor   (r_floor),
        .i_ceiling (r_ceiling)
    );

    always_comb begin
        w_side3    = u2_side;
        w_side3.m2 = u2_mut;
        case (r_mode)
            dege_pkg::MODE_REVDE: begin
                w_base3 = u2_side.word.parent_c;
                w_x3    = u2_side.m1;
                w_y3    = u2_mut;
            end
            dege_pkg::MODE_DEX3: begin
                w_base3 = u2_side.word.parent_a;
                w_x3    = u2_side.word.parent_f;
                w_y3    = u2_side.word.parent_g;
            end
            default: begin
                w_base3 = u2_side.word.parent_c;
                w_x3    = u2_side.word.parent_a;
                w_y3    = u2_side.word.parent_b;
            end
        endcase
    end

    dege_mutate u_mut3 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (u2_valid),
        .o_ready   (u2_ready),
        .i_base    (w_base3),
        .i_x       (w_x3),
        .i_y       (w_y3),
        .i_side    (w_side3),
        .o_valid   (u3_valid),
        .i_ready   (w_en_out),
        .o_mutant  (u3_mut),
        .o_side    (u3_side),
        .i_weight  (r_weight),
        .i_floor   (r_floor),
        .i_ceiling (r_ceiling)
    );

    // uniform crossover against the fallback parents; de mode zeroes the second and third child
    always_comb begin
        n_out.child_one = pick_gene(u3_side.m1, u3_side.word.parent_a,
                                    u3_side.word.draw_one, r_rate);
        if (r_mode == dege_pkg::MODE_DE) begin
            n_out.child_two   = '0;
            n_out.child_three = '0;
        end else begin
            n_out.child_two   = pick_gene(u3_side.m2, u3_side.word.parent_b,
                                          u3_side.word.draw_two, r_rate);
            n_out.child_three = pick_gene(u3_mut, u3_side.word.parent_c,
                                          u3_side.word.draw_three, r_rate);
        end
    end

    assign w_en_out = !r_ov || i_out_ready;
    assign w_load   = u3_valid && w_en_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en_out) begin
            r_ov <= u3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input not ready although the output register drains");

    a_de_zero_children: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_mode == dege_pkg::MODE_DE) |=>
        (o_out_word.child_two == '0 && o_out_word.child_three == '0))
        else $error("de mode word carries nonzero second or third child");

    a_zero_rate_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_rate == '0) |=>
        (o_out_word.child_one == $past(u3_side.word.parent_a)))
        else $error("zero crossover rate did not take the base parent");

endmodule

`default_nettype wire

// ----- rtl/dege_mutate.sv -----
// dege_mutate: five-stage mutation unit, base + F*(x - y) rounded and clamped
`default_nettype none

module dege_mutate (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire dege_pkg::t_gene                   i_base,
    input  wire dege_pkg::t_gene                   i_x,
    input  wire dege_pkg::t_gene                   i_y,
    input  wire dege_pkg::t_side                   i_side,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output dege_pkg::t_gene                        o_mutant,
    output dege_pkg::t_side                        o_side,
    input  wire logic [dege_pkg::WEIGHT_W-1:0]     i_weight,
    input  wire dege_pkg::t_gene                   i_floor,
    input  wire dege_pkg::t_gene                   i_ceiling
);

    localparam int G = dege_pkg::GENE_BITS;
    localparam int N = 5;

    logic [N-1:0]                         r_v;
    logic [N-1:0]                         w_en;
    dege_pkg::t_side                      r_side [N];
    dege_pkg::t_gene                      r_base [N-2];

    logic signed [dege_pkg::MAG_W-1:0]    r_d;
    logic        [dege_pkg::MAG_W-1:0]    r_mag;
    logic                                 r_neg2;
    logic        [dege_pkg::Q_W-1:0]      r_q;
    logic                                 r_neg3;
    logic signed [dege_pkg::S_W-1:0]      r_s;
    dege_pkg::t_gene                      r_mut;

    logic signed [dege_pkg::MAG_W-1:0]    n_d;
    logic        [dege_pkg::MAG_W-1:0]    n_mag;
    logic        [dege_pkg::PROD_W-1:0]   n_prod;
    logic signed [dege_pkg::S_W-1:0]      n_sq;
    logic signed [dege_pkg::S_W-1:0]      n_s;
    logic signed [dege_pkg::S_W-1:0]      w_floor;
    logic signed [dege_pkg::S_W-1:0]      w_ceil;
    logic signed [dege_pkg::S_W-1:0]      w_lo;
    logic signed [dege_pkg::S_W-1:0]      w_cl;

    always_comb begin
        w_en[N-1] = !r_v[N-1] || i_ready;
        for (int k = N - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready  = w_en[0];
    assign o_valid  = r_v[N-1];
    assign o_mutant = r_mut;
    assign o_side   = r_side[N-1];

    // difference, magnitude, scaled product, signed sum, clamp
    assign n_d   = $signed({i_x[G-1], i_x}) - $signed({i_y[G-1], i_y});
    assign n_mag = r_d[dege_pkg::MAG_W-1] ? dege_pkg::MAG_W'(-r_d) : dege_pkg::MAG_W'(r_d);
    assign n_prod = dege_pkg::PROD_W'(r_mag) * dege_pkg::PROD_W'(i_weight)
                  + dege_pkg::PROD_W'(1 << (dege_pkg::F_FRAC - 1));
    assign n_sq  = r_neg3 ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign n_s   = $signed({{(dege_pkg::S_W-G){r_base[2][G-1]}}, r_base[2]}) + n_sq;

    assign w_floor = $signed({{(dege_pkg::S_W-G){i_floor[G-1]}}, i_floor});
    assign w_ceil  = $signed({{(dege_pkg::S_W-G){i_ceiling[G-1]}}, i_ceiling});
    assign w_lo    = (r_s < w_floor) ? w_floor : r_s;
    assign w_cl    = (w_lo > w_ceil) ? w_ceil : w_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < N; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= i_side;
            r_base[0] <= i_base;
            r_d       <= n_d;
        end
        if (w_en[1]) begin
            r_side[1] <= r_side[0];
            r_base[1] <= r_base[0];
            r_mag     <= n_mag;
            r_neg2    <= r_d[dege_pkg::MAG_W-1];
        end
        if (w_en[2]) begin
            r_side[2] <= r_side[1];
            r_base[2] <= r_base[1];
            r_q       <= n_prod[dege_pkg::PROD_W-1:dege_pkg::F_FRAC];
            r_neg3    <= r_neg2;
        end
        if (w_en[3]) begin
            r_side[3] <= r_side[2];
            r_s       <= n_s;
        end
        if (w_en[4]) begin
            r_side[4] <= r_side[3];
            r_mut     <= w_cl[G-1:0];
        end
    end

endmodule

`default_nettype wire
